// ----- sv/fct_pkg.sv -----
// Shared types and constants of the fault code table.
package fct_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int LIMIT_W     = 6;
	localparam int ENTRY_W     = 6;
	localparam int CAP_W       = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 6'd32;
	localparam logic [31:0]        SAT32       = 32'hFFFF_FFFF;

	localparam logic [2:0] OP_REGISTER  = 3'd0;
	localparam logic [2:0] OP_SET       = 3'd1;
	localparam logic [2:0] OP_CLEAR     = 3'd2;
	localparam logic [2:0] OP_LOOKUP    = 3'd3;
	localparam logic [2:0] OP_LIST      = 3'd4;
	localparam logic [2:0] OP_CLR_DIRTY = 3'd5;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_EXISTS    = 3'd2,
		ST_CAPACITY  = 3'd3,
		ST_INVALID   = 3'd4
	} status_t;

	typedef struct packed {
		logic [31:0] id;
		logic [31:0] occ;
		logic [31:0] clr;
		logic [3:0]  flags;
		logic [1:0]  sev;
	} rec_t;

endpackage

// ----- sv/fct_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module fct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/fault_code_table.sv -----
// Fault code table top level: sequencer, record update and output register.
//
// One operation is taken at a time; in_ready is low until its last result is
// loaded into the output register. Records live in a single RAM with one read
// port. The id search reads one entry at a time (S_RD, then S_CMP) until the id
// matches or the last stored entry is read; a register, set, clear or lookup
// then passes S_UPD and S_EMIT. Clear dirty, undefined opcodes and invalid
// registrations go straight to S_EMIT. A list run reads each entry (S_LRD,
// S_LCMP) and gives its result in S_EMIT, which waits while the output register
// is full and out_ready is low. The table needs no clearing pass after reset:
// only entries below the stored count are ever read.
module fault_code_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [31:0] fault_id,
	input  logic [1:0]  severity_in,
	input  logic        active_request,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status_code,
	output logic [31:0] fault_id_out,
	output logic [31:0] occurrences,
	output logic [31:0] clears,
	output logic [3:0]  status_bits,
	output logic [1:0]  severity_out,
	output logic [5:0]  entry_count,
	output logic        dirty,
	output logic        record_valid,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  table_limit
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_CMP  = 7'b0000100,
		S_UPD  = 7'b0001000,
		S_LRD  = 7'b0010000,
		S_LCMP = 7'b0100000,
		S_EMIT = 7'b1000000
	} state_t;

	state_t                          state_q;
	logic [fct_pkg::CNT_W-1:0]       count_q;
	logic                            dirty_q;
	logic [fct_pkg::LIMIT_W-1:0]     limit_q;
	logic [fct_pkg::IDX_W-1:0]       idx_q;
	logic                            out_valid_q;

	logic [2:0]                      op_q;
	logic [31:0]                     id_q;
	logic [1:0]                      sev_q;
	logic                            act_q;
	logic                            found_q;
	fct_pkg::rec_t                   rec_q;
	fct_pkg::status_t                st_q;
	logic                            recv_q;
	logic                            last_q;

	fct_pkg::rec_t                   out_rec_q;
	fct_pkg::status_t                out_st_q;
	logic [fct_pkg::CNT_W-1:0]       out_count_q;
	logic                            out_dirty_q;
	logic                            out_recv_q;
	logic                            out_last_q;

	fct_pkg::rec_t                   ram_rdata;
	logic                            in_xfer;
	logic                            slot_free;
	logic                            at_end;
	logic [fct_pkg::CAP_W-1:0]       limit_ext;
	logic [fct_pkg::CAP_W-1:0]       depth_ext;
	logic [fct_pkg::CAP_W-1:0]       cap;
	logic [fct_pkg::CAP_W-1:0]       count_ext;

	fct_pkg::rec_t                   upd_rec;
	fct_pkg::status_t                upd_st;
	logic                            upd_recv;
	logic                            upd_we;
	logic                            upd_inc;
	logic                            upd_dirty;
	logic [fct_pkg::IDX_W-1:0]       upd_addr;

	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign slot_free = !out_valid_q || out_ready;
	assign at_end    = (fct_pkg::CNT_W'(idx_q) + fct_pkg::CNT_W'(1)) == count_q;

	assign limit_ext = fct_pkg::CAP_W'(limit_q);
	assign depth_ext = fct_pkg::CAP_W'(fct_pkg::TABLE_DEPTH);
	assign cap       = (limit_ext < depth_ext) ? limit_ext : depth_ext;
	assign count_ext = fct_pkg::CAP_W'(count_q);

	fct_ram #(
		.WIDTH($bits(fct_pkg::rec_t)),
		.DEPTH(fct_pkg::TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (upd_we && (state_q == S_UPD)),
		.waddr(upd_addr),
		.wdata(upd_rec),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		upd_rec   = rec_q;
		upd_st    = fct_pkg::ST_OK;
		upd_recv  = 1'b1;
		upd_we    = 1'b0;
		upd_inc   = 1'b0;
		upd_dirty = 1'b0;
		upd_addr  = idx_q;
		case (op_q)
			fct_pkg::OP_REGISTER: begin
				if (found_q) begin
					upd_st = fct_pkg::ST_EXISTS;
				end else if (count_ext >= cap) begin
					upd_st   = fct_pkg::ST_CAPACITY;
					upd_recv = 1'b0;
				end else begin
					upd_rec.id    = id_q;
					upd_rec.occ   = '0;
					upd_rec.clr   = '0;
					upd_rec.flags = '0;
					upd_rec.sev   = sev_q;
					upd_addr      = count_q[fct_pkg::IDX_W-1:0];
					upd_we        = 1'b1;
					upd_inc       = 1'b1;
					upd_dirty     = 1'b1;
				end
			end
			fct_pkg::OP_SET: begin
				if (!found_q) begin
					upd_st   = fct_pkg::ST_NOT_FOUND;
					upd_recv = 1'b0;
				end else begin
					upd_we = 1'b1;
					if (act_q) begin
						upd_rec.flags = 4'hF;
						if (!rec_q.flags[0] && (rec_q.occ != fct_pkg::SAT32)) begin
							upd_rec.occ = rec_q.occ + 32'd1;
						end
					end else begin
						upd_rec.flags = rec_q.flags & 4'b0110;
					end
					upd_dirty = (act_q != rec_q.flags[0]);
				end
			end
			fct_pkg::OP_CLEAR: begin
				if (!found_q) begin
					upd_st   = fct_pkg::ST_NOT_FOUND;
					upd_recv = 1'b0;
				end else if ((rec_q.flags != 4'h0) || (rec_q.occ != 32'd0)) begin
					upd_we        = 1'b1;
					upd_dirty     = 1'b1;
					upd_rec.flags = '0;
					upd_rec.occ   = '0;
					if (rec_q.clr != fct_pkg::SAT32) begin
						upd_rec.clr = rec_q.clr + 32'd1;
					end
				end
			end
			fct_pkg::OP_LOOKUP: begin
				if (!found_q) begin
					upd_st   = fct_pkg::ST_NOT_FOUND;
					upd_recv = 1'b0;
				end
			end
			default: begin
				upd_st   = fct_pkg::ST_INVALID;
				upd_recv = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dirty_q     <= 1'b0;
			limit_q     <= fct_pkg::LIMIT_RESET;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				limit_q <= table_limit;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						idx_q <= '0;
						case (opcode)
							fct_pkg::OP_REGISTER, fct_pkg::OP_SET,
							fct_pkg::OP_CLEAR, fct_pkg::OP_LOOKUP: begin
								if ((opcode == fct_pkg::OP_REGISTER) && (limit_q == '0)) begin
									state_q <= S_EMIT;
								end else if (count_q == '0) begin
									state_q <= S_UPD;
								end else begin
									state_q <= S_RD;
								end
							end
							fct_pkg::OP_LIST: begin
								state_q <= (count_q == '0) ? S_EMIT : S_LRD;
							end
							fct_pkg::OP_CLR_DIRTY: begin
								dirty_q <= 1'b0;
								state_q <= S_EMIT;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (ram_rdata.id == id_q) begin
						state_q <= S_UPD;
					end else if (at_end) begin
						state_q <= S_UPD;
					end else begin
						idx_q   <= idx_q + fct_pkg::IDX_W'(1);
						state_q <= S_RD;
					end
				end
				S_UPD: begin
					if (upd_inc) begin
						count_q <= count_q + fct_pkg::CNT_W'(1);
					end
					if (upd_dirty) begin
						dirty_q <= 1'b1;
					end
					state_q <= S_EMIT;
				end
				S_LRD: begin
					state_q <= S_LCMP;
				end
				S_LCMP: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						if ((op_q == fct_pkg::OP_LIST) && !last_q) begin
							idx_q   <= idx_q + fct_pkg::IDX_W'(1);
							state_q <= S_LRD;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q    <= opcode;
				id_q    <= fault_id;
				sev_q   <= severity_in;
				act_q   <= active_request;
				found_q <= 1'b0;
				recv_q  <= 1'b0;
				last_q  <= 1'b1;
				if ((opcode == fct_pkg::OP_REGISTER) && (limit_q == '0)) begin
					st_q <= fct_pkg::ST_INVALID;
				end else if (opcode > fct_pkg::OP_CLR_DIRTY) begin
					st_q <= fct_pkg::ST_INVALID;
				end else begin
					st_q <= fct_pkg::ST_OK;
				end
			end
			S_CMP: begin
				rec_q <= ram_rdata;
				if (ram_rdata.id == id_q) begin
					found_q <= 1'b1;
				end
			end
			S_UPD: begin
				rec_q  <= upd_rec;
				st_q   <= upd_st;
				recv_q <= upd_recv;
				last_q <= 1'b1;
			end
			S_LCMP: begin
				rec_q  <= ram_rdata;
				st_q   <= fct_pkg::ST_OK;
				recv_q <= 1'b1;
				last_q <= at_end;
			end
			S_EMIT: begin
				if (slot_free) begin
					out_rec_q   <= recv_q ? rec_q : '0;
					out_st_q    <= st_q;
					out_count_q <= count_q;
					out_dirty_q <= dirty_q;
					out_recv_q  <= recv_q;
					out_last_q  <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid    = out_valid_q;
	assign status_code  = out_st_q;
	assign fault_id_out = out_rec_q.id;
	assign occurrences  = out_rec_q.occ;
	assign clears       = out_rec_q.clr;
	assign status_bits  = out_rec_q.flags;
	assign severity_out = out_rec_q.sev;
	assign entry_count  = fct_pkg::ENTRY_W'(out_count_q);
	assign dirty        = out_dirty_q;
	assign record_valid = out_recv_q;
	assign last         = out_last_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fct_pkg::CNT_W'(fct_pkg::TABLE_DEPTH))
		else $error("stored count beyond table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + fct_pkg::CNT_W'(1)))
		else $error("stored count moved by other than one");

	a_no_record_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !record_valid) |-> ((fault_id_out == 32'd0) && (occurrences == 32'd0)
		&& (clears == 32'd0) && (status_bits == 4'd0) && (severity_out == 2'd0)))
		else $error("record fields not cleared without a record");

	a_exists_has_record: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status_code == fct_pkg::ST_EXISTS)) |-> record_valid)
		else $error("duplicate report without its record");
`endif

endmodule

// ----- dv/tb_fault_code_table.sv -----
// Testbench for the fault code table: queued operations, a shadow table and per-result checks.
`timescale 1ns / 100ps

module tb_fault_code_table;

	localparam logic [2:0] OP_UNDEF_LO = 3'd6;
	localparam logic [2:0] OP_UNDEF_HI = 3'd7;
	localparam int MAX_GAP        = 18;
	localparam int LONG_HOLD      = 200;
	localparam int LONG_HOLD_AT   = 40;
	localparam int SETTLE_CYCLES  = 80;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] id;
		logic [1:0]  sev;
		logic        act;
	} fault_req_t;

	typedef struct packed {
		fct_pkg::status_t status;
		fct_pkg::rec_t    rec;
		logic [5:0]       count;
		logic             dirty;
		logic             rec_valid;
		logic             last;
	} fault_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  opcode = fct_pkg::OP_REGISTER;
	logic [31:0] fault_id = '0;
	logic [1:0]  severity_in = '0;
	logic        active_request = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status_code;
	logic [31:0] fault_id_out;
	logic [31:0] occurrences;
	logic [31:0] clears;
	logic [3:0]  status_bits;
	logic [1:0]  severity_out;
	logic [5:0]  entry_count;
	logic        dirty;
	logic        record_valid;
	logic        last;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  table_limit = fct_pkg::LIMIT_RESET;

	fault_req_t    request_queue[$];
	fault_report_t expected_reports[$];
	logic [31:0]   id_pool[$];

	fct_pkg::rec_t shadow_rec[fct_pkg::TABLE_DEPTH];
	int   shadow_count = 0;
	logic shadow_dirty = 1'b0;
	int   shadow_limit = fct_pkg::LIMIT_RESET;

	int tx_gap = 0;
	int rx_hold = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int reports_seen = 0;
	int mismatches = 0;
	int idle_cycles = 0;

	fault_code_table dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int find_record(logic [31:0] id);
		for (int i = 0; i < shadow_count; i++)
			if (shadow_rec[i].id == id)
				return i;
		return -1;
	endfunction

	function automatic void add_report(fct_pkg::status_t st, int idx, logic lst);
		fault_report_t r;
		r.status = st;
		r.rec = (idx >= 0) ? shadow_rec[idx] : '0;
		r.count = 6'(shadow_count);
		r.dirty = shadow_dirty;
		r.rec_valid = (idx >= 0);
		r.last = lst;
		expected_reports.push_back(r);
	endfunction

	function automatic void predict_reports(fault_req_t q);
		int   cap;
		int   idx;
		logic was;
		cap = (shadow_limit < fct_pkg::TABLE_DEPTH) ? shadow_limit : fct_pkg::TABLE_DEPTH;
		case (q.op)
			fct_pkg::OP_REGISTER: begin
				idx = find_record(q.id);
				if (cap == 0) begin
					add_report(fct_pkg::ST_INVALID, -1, 1'b1);
				end else if (idx >= 0) begin
					add_report(fct_pkg::ST_EXISTS, idx, 1'b1);
				end else if (shadow_count >= cap) begin
					add_report(fct_pkg::ST_CAPACITY, -1, 1'b1);
				end else begin
					shadow_rec[shadow_count] = {q.id, 32'd0, 32'd0, 4'd0, q.sev};
					shadow_count++;
					shadow_dirty = 1'b1;
					add_report(fct_pkg::ST_OK, shadow_count - 1, 1'b1);
				end
			end
			fct_pkg::OP_SET, fct_pkg::OP_CLEAR, fct_pkg::OP_LOOKUP: begin
				idx = find_record(q.id);
				if (idx < 0) begin
					add_report(fct_pkg::ST_NOT_FOUND, -1, 1'b1);
				end else begin
					if (q.op == fct_pkg::OP_SET) begin
						was = shadow_rec[idx].flags[0];
						if (q.act) begin
							shadow_rec[idx].flags = 4'hF;
							if (!was && shadow_rec[idx].occ != fct_pkg::SAT32)
								shadow_rec[idx].occ += 1;
						end else begin
							shadow_rec[idx].flags = shadow_rec[idx].flags & 4'h6;
						end
						if (q.act != was)
							shadow_dirty = 1'b1;
					end else if (q.op == fct_pkg::OP_CLEAR) begin
						if (shadow_rec[idx].flags != 0 || shadow_rec[idx].occ != 0) begin
							shadow_rec[idx].flags = '0;
							shadow_rec[idx].occ = '0;
							if (shadow_rec[idx].clr != fct_pkg::SAT32)
								shadow_rec[idx].clr += 1;
							shadow_dirty = 1'b1;
						end
					end
					add_report(fct_pkg::ST_OK, idx, 1'b1);
				end
			end
			fct_pkg::OP_LIST: begin
				if (shadow_count == 0)
					add_report(fct_pkg::ST_OK, -1, 1'b1);
				for (int i = 0; i < shadow_count; i++)
					add_report(fct_pkg::ST_OK, i, i == shadow_count - 1);
			end
			fct_pkg::OP_CLR_DIRTY: begin
				shadow_dirty = 1'b0;
				add_report(fct_pkg::ST_OK, -1, 1'b1);
			end
			default: begin
				add_report(fct_pkg::ST_INVALID, -1, 1'b1);
			end
		endcase
	endfunction

	function automatic void queue_op(logic [2:0] op, logic [31:0] id, logic [1:0] sev,
			logic act);
		request_queue.push_back({op, id, sev, act});
	endfunction

	function automatic logic [31:0] pick_id(int fresh_pct, bit remember);
		logic [31:0] id;
		if (id_pool.size() == 0 || $urandom_range(0, 99) < fresh_pct) begin
			case ($urandom_range(0, 7))
				0: id = 32'h0000_0000;
				1: id = 32'hFFFF_FFFF;
				default: id = $urandom();
			endcase
			if (remember)
				id_pool.push_back(id);
		end else begin
			id = id_pool[$urandom_range(0, id_pool.size() - 1)];
		end
		return id;
	endfunction

	function automatic void queue_random(int count, int reg_pct);
		int roll;
		repeat (count) begin
			roll = $urandom_range(0, reg_pct + 71);
			if (roll < reg_pct)
				queue_op(fct_pkg::OP_REGISTER, pick_id(60, 1'b1), 2'($urandom),
					1'($urandom));
			else if (roll < reg_pct + 30)
				queue_op(fct_pkg::OP_SET, pick_id(8, 1'b0), 2'($urandom), 1'($urandom));
			else if (roll < reg_pct + 42)
				queue_op(fct_pkg::OP_CLEAR, pick_id(8, 1'b0), 2'($urandom), 1'($urandom));
			else if (roll < reg_pct + 57)
				queue_op(fct_pkg::OP_LOOKUP, pick_id(15, 1'b0), 2'($urandom),
					1'($urandom));
			else if (roll < reg_pct + 62)
				queue_op(fct_pkg::OP_LIST, $urandom(), 2'($urandom), 1'($urandom));
			else if (roll < reg_pct + 68)
				queue_op(fct_pkg::OP_CLR_DIRTY, $urandom(), 2'($urandom), 1'($urandom));
			else
				queue_op(3'($urandom), $urandom(), 2'($urandom), 1'($urandom));
		end
	endfunction

	task automatic drain_ops();
		do @(negedge clk);
		while (request_queue.size() != 0 || in_valid || expected_reports.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_limit(logic [5:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		table_limit <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		shadow_limit = value;
	endtask

	always @(posedge clk or negedge arst_n) begin : tx_side
		fault_req_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				predict_reports({opcode, fault_id, severity_in, active_request});
			if (!in_valid || in_ready) begin
				if (tx_gap != 0) begin
					tx_gap <= tx_gap - 1;
					in_valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					nxt = request_queue.pop_front();
					in_valid <= 1'b1;
					opcode <= nxt.op;
					fault_id <= nxt.id;
					severity_in <= nxt.sev;
					active_request <= nxt.act;
					if ($urandom_range(0, 15) == 0)
						tx_steady = !tx_steady;
					tx_gap <= tx_steady ? 0 : $urandom_range(0, MAX_GAP);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : rx_side
		fault_report_t want;
		fault_report_t got;
		int            rx_next;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {status_code, fault_id_out, occurrences, clears, status_bits,
					severity_out, entry_count, dirty, record_valid, last};
				if (expected_reports.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("unexpected result: st %0d id %h rv %b", got.status,
							got.rec.id, got.rec_valid);
				end else begin
					want = expected_reports.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("result %0d mismatch", reports_seen);
							$display("  expected st %0d id %h occ %h clr %h bits %h",
								want.status, want.rec.id, want.rec.occ, want.rec.clr,
								want.rec.flags);
							$display("    sev %0d cnt %0d dirty %b rv %b last %b",
								want.rec.sev, want.count, want.dirty, want.rec_valid,
								want.last);
							$display("  got st %0d id %h occ %h clr %h bits %h",
								got.status, got.rec.id, got.rec.occ, got.rec.clr,
								got.rec.flags);
							$display("    sev %0d cnt %0d dirty %b rv %b last %b",
								got.rec.sev, got.count, got.dirty, got.rec_valid,
								got.last);
						end
					end
				end
				reports_seen++;
				if ($urandom_range(0, 15) == 0)
					rx_steady = !rx_steady;
				if (reports_seen == LONG_HOLD_AT)
					rx_next = LONG_HOLD;
				else
					rx_next = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
			end else begin
				rx_next = (rx_hold > 0) ? rx_hold - 1 : 0;
			end
			rx_hold <= rx_next;
			out_ready <= (rx_next == 0);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		id_pool.push_back(32'h0000_0000);
		id_pool.push_back(32'hFFFF_FFFF);
		id_pool.push_back(32'h5A5A_0001);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		write_limit(fct_pkg::LIMIT_RESET);
		queue_op(fct_pkg::OP_LIST, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_LOOKUP, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_SET, 32'h0000_0000, 2'd0, 1'b1);
		queue_op(fct_pkg::OP_CLEAR, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_CLR_DIRTY, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(OP_UNDEF_LO, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(OP_UNDEF_HI, 32'hFFFF_FFFF, 2'd3, 1'b1);
		queue_op(fct_pkg::OP_REGISTER, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_REGISTER, 32'hFFFF_FFFF, 2'd3, 1'b1);
		queue_op(fct_pkg::OP_REGISTER, 32'hFFFF_FFFF, 2'd1, 1'b0);
		queue_op(fct_pkg::OP_SET, 32'h0000_0000, 2'd0, 1'b1);
		queue_op(fct_pkg::OP_SET, 32'h0000_0000, 2'd0, 1'b1);
		queue_op(fct_pkg::OP_SET, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_SET, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_CLEAR, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_CLEAR, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_SET, 32'hFFFF_FFFF, 2'd0, 1'b1);
		queue_op(fct_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_LIST, 32'h0000_0000, 2'd0, 1'b0);
		queue_op(fct_pkg::OP_CLR_DIRTY, 32'h0000_0000, 2'd0, 1'b0);
		drain_ops();

		// registration disabled, stored records still reachable
		write_limit(6'd0);
		queue_op(fct_pkg::OP_REGISTER, 32'h5A5A_0001, 2'd2, 1'b0);
		queue_op(fct_pkg::OP_LOOKUP, 32'hFFFF_FFFF, 2'd0, 1'b0);
		drain_ops();

		write_limit(6'd2);
		queue_op(fct_pkg::OP_REGISTER, 32'h5A5A_0001, 2'd2, 1'b0);
		drain_ops();

		write_limit(6'd3);
		queue_op(fct_pkg::OP_REGISTER, 32'h5A5A_0001, 2'd2, 1'b0);
		queue_op(fct_pkg::OP_REGISTER, 32'hA5A5_FFFE, 2'd1, 1'b1);
		queue_op(fct_pkg::OP_LIST, 32'h0000_0000, 2'd0, 1'b0);
		drain_ops();

		write_limit(6'd63);
		queue_random(20, 35);
		drain_ops();

		write_limit(6'($urandom_range(1, 31)));
		queue_random(20, 20);
		drain_ops();

		// register 24 more ids with the limit at the table depth, then list the table whole
		write_limit(6'd32);
		repeat (24)
			queue_op(fct_pkg::OP_REGISTER, pick_id(100, 1'b1), 2'($urandom), 1'($urandom));
		queue_op(fct_pkg::OP_LIST, $urandom(), 2'($urandom), 1'($urandom));
		queue_random(20, 20);
		drain_ops();
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
sv/fct_pkg.sv
sv/fct_ram.sv
sv/fault_code_table.sv
dv/tb_fault_code_table.sv
